### rtl/ttrc_pkg.sv
// Shared constants and types for the three-term recurrence checksum block.
package ttrc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned TERM_W = 16;

    // Offset added to the first byte of a message
    localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
    // Position multipliers, taken modulo 256
    localparam logic [BYTE_W-1:0] ALPHA_MUL = 8'd17;
    localparam logic [BYTE_W-1:0] BETA_MUL  = 8'd31;
    // Fold modulus 2^16 - 1
    localparam logic [16:0] FOLD_MOD = 17'd65535;
    // 257 * 65535, lifts the signed difference above zero before folding
    localparam logic [25:0] FOLD_BIAS = 26'd16842495;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [TERM_W-1:0] term_t;

endpackage

### rtl/three_term_recurrence_checksum_top.sv
// Three-term recurrence checksum over a stream of message bytes.
//   Path: the checksum of a message passes the input register and then the result
//   register on its way to m_tdata after its last word is accepted.
//   Throughput: one byte per cycle; a last word holds in the input register while an
//   earlier checksum still waits on m_tready.
//   Reset: aresetn (synchronous, active low) empties both registers and sets
//   the terms to one, the position to zero, awaiting the first byte.
module three_term_recurrence_checksum_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] checksum
);

    // Input register
    logic                in_valid_reg, in_valid_next;
    ttrc_pkg::byte_t     in_byte_reg;
    logic                in_last_reg;

    // Recurrence state
    ttrc_pkg::term_t     prev_reg, prev_next;
    ttrc_pkg::term_t     cur_reg, cur_next;
    ttrc_pkg::byte_t     pos_reg, pos_next;
    logic                mid_reg, mid_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    ttrc_pkg::term_t     out_data_reg;

    logic                advance;
    logic                s_accept;

    // Datapath
    ttrc_pkg::byte_t     alpha;
    ttrc_pkg::byte_t     beta;
    logic [8:0]          coef;
    logic [24:0]         lhs;
    logic [23:0]         rhs;
    logic [25:0]         diff;
    logic [25:0]         lifted;
    logic [16:0]         fold1;
    logic [16:0]         fold2;
    ttrc_pkg::term_t     rec_term;
    ttrc_pkg::term_t     new_cur;

    // Advance the held word when it yields no result or the result slot frees
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Position coefficients, both modulo 256
    assign alpha = ttrc_pkg::BYTE_W'(pos_reg * ttrc_pkg::ALPHA_MUL);
    assign beta  = ttrc_pkg::BYTE_W'(pos_reg * ttrc_pkg::BETA_MUL);
    assign coef  = {1'b0, in_byte_reg} + {1'b0, alpha};

    assign lhs = 25'(coef) * 25'(cur_reg);
    assign rhs = 24'(beta) * 24'(prev_reg);

    // Two's complement difference; a negative value stands in for a wrap through 2^64,
    // which is congruent to one, so add one when the sign is set
    assign diff   = {1'b0, lhs} - {2'b00, rhs};
    assign lifted = diff + {25'd0, diff[25]} + ttrc_pkg::FOLD_BIAS;

    // Fold by 2^16 - 1: high half adds onto the low half, twice, then trim
    assign fold1 = {7'd0, lifted[25:16]} + {1'b0, lifted[15:0]};
    assign fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
    assign rec_term = (fold2 >= ttrc_pkg::FOLD_MOD) ?
                      ttrc_pkg::TERM_W'(fold2 - ttrc_pkg::FOLD_MOD) :
                      fold2[15:0];

    // First byte seeds the current term
    assign new_cur = mid_reg ? rec_term :
                     (ttrc_pkg::TERM_W'(in_byte_reg) + ttrc_pkg::FIRST_OFFSET);

    always_comb begin
        prev_next = prev_reg;
        cur_next  = cur_reg;
        pos_next  = pos_reg;
        mid_next  = mid_reg;
        if (advance) begin
            if (in_last_reg) begin
                // Drop back to the reset state once the message closes
                prev_next = 16'd1;
                cur_next  = 16'd1;
                pos_next  = '0;
                mid_next  = 1'b0;
            end else begin
                prev_next = mid_reg ? cur_reg : 16'd1;
                cur_next  = new_cur;
                pos_next  = mid_reg ? pos_reg + 8'd1 : 8'd1;
                mid_next  = 1'b1;
            end
        end
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_reg      <= 16'd1;
            cur_reg       <= 16'd1;
            pos_reg       <= '0;
            mid_reg       <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            pos_reg       <= pos_next;
            mid_reg       <= mid_next;
        end
    end

    // Payload registers: input ones load on acceptance, the result one when a last word advances; hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_data_reg <= new_cur;
        end
    end

endmodule

### verif/ttrc_checker.sv
// Watches both channels of the checksum block, predicts each checksum and compares it.
module ttrc_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [15:0] checksum
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ttrc_pkg::term_t older_term;
    ttrc_pkg::term_t newer_term;
    ttrc_pkg::byte_t next_pos;
    logic            in_message;
    ttrc_pkg::term_t expected_sums[$];

    task automatic clear_recurrence();
        older_term = 16'd1;
        newer_term = 16'd1;
        next_pos   = '0;
        in_message = 1'b0;
    endtask

    // advance the recurrence by one byte; queue the checksum on the last byte
    task automatic fold_byte(input ttrc_pkg::byte_t data_b, input logic last_b);
        logic [63:0] alpha, beta, lhs, rhs, folded;
        if (!in_message) begin
            older_term = 16'd1;
            newer_term = ttrc_pkg::term_t'(data_b) + ttrc_pkg::FIRST_OFFSET;
            next_pos   = 8'd1;
            in_message = 1'b1;
        end else begin
            alpha  = (64'(next_pos) * 64'(ttrc_pkg::ALPHA_MUL)) & 64'hFF;
            beta   = (64'(next_pos) * 64'(ttrc_pkg::BETA_MUL)) & 64'hFF;
            lhs    = (64'(data_b) + alpha) * 64'(newer_term);
            rhs    = beta * 64'(older_term);
            // unsigned 64-bit wrap of a negative difference is intended
            folded = (lhs - rhs) % 64'(ttrc_pkg::FOLD_MOD);
            older_term = newer_term;
            newer_term = ttrc_pkg::term_t'(folded);
            next_pos   = next_pos + 8'd1;
        end
        if (last_b) begin
            expected_sums.push_back(newer_term);
            clear_recurrence();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_recurrence();
            expected_sums.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected none, actual checksum %h", $time, m_tdata);
                end else begin
                    if (m_tdata !== expected_sums[0]) begin
                        fail_count++;
                        $display("%0t: checksum expected %h, actual %h",
                                 $time, expected_sums[0], m_tdata);
                    end
                    void'(expected_sums.pop_front());
                end
            end
            if (s_tvalid && s_tready)
                fold_byte(s_tdata, s_tlast);
        end
        pending = expected_sums.size();
    end

endmodule

### verif/tb_three_term_recurrence_checksum_top.sv
// Stimulus and verdict for the three-term recurrence checksum block.
module tb_three_term_recurrence_checksum_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;   // [7:0] data_byte
    logic        s_tlast  = 1'b0; // last_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [15:0] checksum

    int fail_count;
    int pending;

    // gap-free stretches on either side, switched per message
    logic quiet_source = 1'b0;
    logic quiet_sink   = 1'b0;

    // 2 ns half period gives the 4 ns clock
    always #2 aclk = ~aclk;

    three_term_recurrence_checksum_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ttrc_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Offer one word: idle for a drawn number of cycles, then hold it until taken.
    // Changes happen on the falling edge; the handshake is judged on the rising one.
    // With no gap the valid simply stays high and only the data moves on.
    task automatic send_word(input ttrc_pkg::byte_t data_b, input logic last_b);
        int gap;
        gap = quiet_source ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data_b;
        s_tlast  <= last_b;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Lean towards the extremes now and then so that both ends of the byte show up often.
    function automatic ttrc_pkg::byte_t pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return ttrc_pkg::byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // A whole message of random bytes, flag set on the final one.
    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_word(pick_byte(), i == len - 1);
    endtask

    // Result side: stall for a drawn number of cycles, then accept one word.
    initial begin : result_sink
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            stall = quiet_sink ? 0 : $urandom_range(0, 10);
            @(negedge aclk);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int sent;
        int len;
        int long_msgs;
        sent      = 0;
        long_msgs = 0;

        // hold reset, then release on a falling edge
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // one-byte messages: checksum is the byte plus seven, at both ends
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        // two top bytes, then all-zero bytes
        send_word(8'hFF, 1'b0);
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        // alternating bit patterns so every data bit toggles mid-message
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'h0F, 1'b0);
        send_word(8'hF0, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFE, 1'b0);
        send_word(8'h33, 1'b1);

        // Random messages, mostly short; two run past 256 bytes so the position wraps.
        while (sent < 1100) begin
            quiet_source = ($urandom_range(0, 5) == 0);
            quiet_sink   = ($urandom_range(0, 5) == 0);
            if (long_msgs < 2 &&
                ($urandom_range(0, 30) == 0 || sent > 400 * (long_msgs + 1))) begin
                len = $urandom_range(257, 300);
                long_msgs++;
            end else begin
                len = $urandom_range(1, 12);
            end
            send_message(len);
            sent += len;
        end

        // drop valid once the final word is in
        @(negedge aclk);
        s_tvalid <= 1'b0;
        quiet_sink = 1'b0;

        // drain outstanding checksums, then allow the pipeline to settle
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin : watchdog
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
